[hw/rtl/dmht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmht_pkg
// Shared constants and types of the direct-mapped hash table: table geometry,
// hash constants, action and kind codes, and the layout of one stored slot.
// ----------------------------------------------------------------------------
package dmht_pkg;

  // table geometry, slot count is a power of two so the slot is a bit field
  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);

  // hash mixing constants
  localparam logic [63:0] HASH_MULT  = 64'hff51afd7ed558ccd;
  localparam int unsigned HASH_SHIFT = 32;

  // action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_STORE  = 1'b1;

  // entry kind that marks a slot as empty
  localparam logic [1:0] KIND_EMPTY = 2'd0;

  // payload of one slot, kind lives in its own memory
  typedef struct packed {
    logic [63:0]        key;
    logic [63:0]        move;
    logic signed [15:0] score;
    logic [5:0]         depth;
  } slot_data_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_MUL0   = 6'b000100,
    ST_MUL1   = 6'b001000,
    ST_MUL2   = 6'b010000,
    ST_ACCESS = 6'b100000
  } state_t;

  // result stage is folded into a flag so the enum stays one-hot over six codes
endpackage
`default_nettype wire

[hw/rtl/direct_mapped_hash_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_top
// Direct-mapped hash table keyed by a 64-bit position word. Lookups return
// the stored entry on a key match in an occupied slot, stores overwrite.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: action,
//   key, best_move, score_in, search_depth, entry_kind. Output channel
//   (out_valid/out_ready) carries one result item per lookup; a store gives
//   no result. On a miss hit is 0 and all other result fields are zero.
//   The slot index hashes the key with a 64-bit multiply done as three
//   32x32 partial products on one shared multiplier, one per cycle.
//   Sequence: an item passes the states MUL0, MUL1, MUL2 and ACCESS. A
//   store writes its slot in ACCESS; a lookup reads the slot memories
//   there synchronously, and the read data goes to the output register
//   once it is free. One item at a time: no new item until IDLE again.
//   Reset: after rst the block sweeps the kind memory to empty, one slot a
//   cycle, over all TABLE_SLOTS (4096) slots with in_ready low.
//   Stall: the result sits in an output register; the next item is
//   accepted while it waits, and a finished lookup holds its read data
//   until the output register is free.
// ----------------------------------------------------------------------------
module direct_mapped_hash_table_top
  import dmht_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic [63:0]        key,
  input  wire logic [63:0]        best_move,
  input  wire logic signed [15:0] score_in,
  input  wire logic [5:0]         search_depth,
  input  wire logic [1:0]         entry_kind,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic [63:0]             move_out,
  output logic signed [15:0]      score_out,
  output logic [5:0]              depth_out,
  output logic [1:0]              kind_out
);

  // slot memories
  logic [1:0] kind_mem [TABLE_SLOTS];
  slot_data_t data_mem [TABLE_SLOTS];

  // control
  state_t           state, state_next;
  logic [IDX_W-1:0] clr_addr;
  logic             rd_pend;

  // captured item
  logic             act_q;
  logic [1:0]       kind_q;
  slot_data_t       data_q;
  logic [63:0]      mix_q;
  logic [63:0]      acc;

  // memory ports
  logic             kind_we, data_we, mem_re;
  logic [IDX_W-1:0] kind_wa, slot_idx;
  logic [1:0]       kind_wd;
  logic [1:0]       kind_rd;
  slot_data_t       data_rd;

  // shared multiplier
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;

  logic             in_fire, out_free, res_load, match;

  assign in_ready = (state == ST_IDLE) && !rd_pend;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign res_load = rd_pend && out_free;

  // slot index from the mixed product
  assign slot_idx = acc[IDX_W-1:0] ^ acc[HASH_SHIFT +: IDX_W];

  // multiplier operand select over the three partial products
  always_comb begin
    unique case (state)
      ST_MUL1: begin
        mul_a = mix_q[31:0];
        mul_b = HASH_MULT[63:32];
      end
      ST_MUL2: begin
        mul_a = mix_q[63:32];
        mul_b = HASH_MULT[31:0];
      end
      default: begin
        mul_a = mix_q[31:0];
        mul_b = HASH_MULT[31:0];
      end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == IDX_W'(TABLE_SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_fire) state_next = ST_MUL0;
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // memory port control: clearing sweep or one access per item
  always_comb begin
    kind_we = 1'b0;
    kind_wa = slot_idx;
    kind_wd = kind_q;
    data_we = 1'b0;
    mem_re  = 1'b0;
    if (state == ST_CLEAR) begin
      kind_we = 1'b1;
      kind_wa = clr_addr;
      kind_wd = KIND_EMPTY;
    end else if (state == ST_ACCESS) begin
      if (act_q == ACT_STORE) begin
        kind_we = 1'b1;
        data_we = 1'b1;
      end else begin
        mem_re  = 1'b1;
      end
    end
  end

  // kind memory
  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[kind_wa] <= kind_wd;
    end
    if (mem_re) begin
      kind_rd <= kind_mem[slot_idx];
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[slot_idx] <= data_q;
    end
    if (mem_re) begin
      data_rd <= data_mem[slot_idx];
    end
  end

  // sequencer and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (mem_re) begin
        rd_pend <= 1'b1;
      end else if (res_load) begin
        rd_pend <= 1'b0;
      end
    end
  end

  // item capture and hash accumulation
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_q       <= action;
      kind_q      <= entry_kind;
      data_q.key  <= key;
      data_q.move <= best_move;
      data_q.score <= score_in;
      data_q.depth <= search_depth;
      mix_q       <= key ^ {32'd0, key[63:32]};
    end
    if (state == ST_MUL0) begin
      acc <= mul_p;
    end else if (state == ST_MUL1 || state == ST_MUL2) begin
      acc[63:32] <= acc[63:32] + mul_p[31:0];
    end
  end

  // key compare on the read slot
  assign match = (kind_rd != KIND_EMPTY) && (data_rd.key == data_q.key);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hit <= match;
      if (match) begin
        move_out  <= data_rd.move;
        score_out <= data_rd.score;
        depth_out <= data_rd.depth;
        kind_out  <= kind_rd;
      end else begin
        move_out  <= '0;
        score_out <= '0;
        depth_out <= '0;
        kind_out  <= '0;
      end
    end
  end

  // store never produces a result item
  a_store_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCESS && act_q == ACT_STORE) |=> !$rose(out_valid))
    else $error("result item raised by a store");

  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (move_out == 64'd0 && score_out == 16'sd0 &&
                             depth_out == 6'd0 && kind_out == KIND_EMPTY))
    else $error("miss with nonzero fields");

  // a hit always comes from an occupied slot
  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (kind_out != KIND_EMPTY))
    else $error("hit on an empty slot");

  // no item taken while a lookup waits for the output register
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !in_ready)
    else $error("item accepted with a pending lookup");

endmodule
`default_nettype wire

[bench/dmht_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmht_checker
// Watches the request and result channels of the direct-mapped hash table,
// keeps a shadow copy of the slot store, predicts the result of every
// accepted lookup and compares it with the result items in order.
// ----------------------------------------------------------------------------
module dmht_checker
  import dmht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic [63:0]        key,
  input  logic [63:0]        best_move,
  input  logic signed [15:0] score_in,
  input  logic [5:0]         search_depth,
  input  logic [1:0]         entry_kind,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               hit,
  input  logic [63:0]        move_out,
  input  logic signed [15:0] score_out,
  input  logic [5:0]         depth_out,
  input  logic [1:0]         kind_out,
  output int                 fail_count,
  output int                 pending
);

  localparam int REPORT_LIMIT = 10;

  // one lookup answer as it appears on the result channel
  typedef struct packed {
    logic               hit;
    logic [63:0]        move;
    logic signed [15:0] score;
    logic [5:0]         depth;
    logic [1:0]         kind;
  } probe_result_t;

  // shadow slot store
  logic [1:0]         shadow_kind  [TABLE_SLOTS];
  logic [63:0]        shadow_key   [TABLE_SLOTS];
  logic [63:0]        shadow_move  [TABLE_SLOTS];
  logic signed [15:0] shadow_score [TABLE_SLOTS];
  logic [5:0]         shadow_depth [TABLE_SLOTS];

  probe_result_t lookup_answers[$];
  int            errors = 0;
  int            results_seen = 0;

  assign fail_count = errors;

  // slot index: fold high half in, multiply, fold again, keep the low bits
  function automatic int unsigned home_slot(input logic [63:0] k);
    logic [63:0] h;
    h = k ^ (k >> HASH_SHIFT);
    h = h * HASH_MULT;
    h = h ^ (h >> HASH_SHIFT);
    return int'(h % 64'(TABLE_SLOTS));
  endfunction

  initial pending = 0;

  // compare results, then apply the accepted request to the shadow store
  always @(posedge clk) begin : track
    probe_result_t want;
    probe_result_t got;
    int unsigned   s;
    if (rst) begin
      for (int n = 0; n < TABLE_SLOTS; n++) shadow_kind[n] = KIND_EMPTY;
      lookup_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {hit, move_out, score_out, depth_out, kind_out};
        if (lookup_answers.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("result %0d arrived with no lookup waiting: hit=%0b move=%h score=%0d depth=%0d kind=%0d",
                     results_seen, got.hit, got.move, got.score, got.depth, got.kind);
          errors++;
        end else begin
          want = lookup_answers.pop_front();
          if (got.hit !== want.hit || got.move !== want.move || got.score !== want.score ||
              got.depth !== want.depth || got.kind !== want.kind) begin
            if (errors < REPORT_LIMIT) begin
              $display("result %0d expected hit=%0b move=%h score=%0d depth=%0d kind=%0d",
                       results_seen, want.hit, want.move, want.score, want.depth, want.kind);
              $display("result %0d actual   hit=%0b move=%h score=%0d depth=%0d kind=%0d",
                       results_seen, got.hit, got.move, got.score, got.depth, got.kind);
            end
            errors++;
          end
        end
        results_seen++;
      end

      if (in_valid && in_ready) begin
        s = home_slot(key);
        if (action == ACT_STORE) begin
          // store overwrites the whole slot, kind zero leaves it empty
          shadow_key[s]   = key;
          shadow_move[s]  = best_move;
          shadow_score[s] = score_in;
          shadow_depth[s] = search_depth;
          shadow_kind[s]  = entry_kind;
        end else if (shadow_kind[s] != KIND_EMPTY && shadow_key[s] == key) begin
          want = {1'b1, shadow_move[s], shadow_score[s], shadow_depth[s], shadow_kind[s]};
          lookup_answers.push_back(want);
        end else begin
          lookup_answers.push_back('0);
        end
      end
    end
    pending <= lookup_answers.size();
  end

endmodule

[bench/direct_mapped_hash_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_top_tb
// Drives lookups and stores into the hash table with random gaps on both
// channels: directed corner cases first, then random items built around a
// small pool of keys that includes pairs sharing one slot, so hits, key
// mismatches, overwrites and empty-kind stores all occur often.
// ----------------------------------------------------------------------------
module direct_mapped_hash_table_top_tb;
  import dmht_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int POOL_PAIRS     = 8;
  localparam int POOL_SIZE      = 2 * POOL_PAIRS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = ACT_LOOKUP;
  logic [63:0]        key = '0;
  logic [63:0]        best_move = '0;
  logic signed [15:0] score_in = '0;
  logic [5:0]         search_depth = '0;
  logic [1:0]         entry_kind = KIND_EMPTY;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [63:0]        move_out;
  logic signed [15:0] score_out;
  logic [5:0]         depth_out;
  logic [1:0]         kind_out;
  int                 fail_count;
  int                 pending;

  logic               steady = 1'b0;
  int                 quiet_cycles = 0;
  logic [63:0]        key_pool [POOL_SIZE];

  direct_mapped_hash_table_top DUT (.*);

  dmht_checker CHK (.*);

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random outside the steady window
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  // watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("direct_mapped_hash_table_top: mismatch");
      $finish;
    end
  end

  // present one request item and hold it until accepted
  task automatic send_item(input logic act, input logic [63:0] k, input logic [63:0] m,
                           input logic signed [15:0] s, input logic [5:0] d,
                           input logic [1:0] kd);
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    action       <= act;
    key          <= k;
    best_move    <= m;
    score_in     <= s;
    search_depth <= d;
    entry_kind   <= kd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic lookup(input logic [63:0] k);
    send_item(ACT_LOOKUP, k, {$urandom, $urandom}, 16'($urandom_range(16'hffff)),
              6'($urandom_range(63)), 2'($urandom_range(3)));
  endtask

  initial begin : stimulus
    logic [63:0] cand;
    logic [63:0] k;
    logic [63:0] ka;
    logic [63:0] kb;
    logic        act;
    logic [1:0]  kd;
    int          r;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // key pool made of pairs that land in the same slot
    for (int p = 0; p < POOL_PAIRS; p++) begin
      key_pool[2*p] = {$urandom, $urandom};
      do begin
        cand = {$urandom, $urandom};
      end while (cand == key_pool[2*p] ||
                 CHK.home_slot(cand) != CHK.home_slot(key_pool[2*p]));
      key_pool[2*p+1] = cand;
    end
    ka = key_pool[0];
    kb = key_pool[1];

    // empty table misses on the extreme keys
    lookup(64'h0);
    lookup('1);
    // extreme payloads stored and read back
    send_item(ACT_STORE, 64'h0, '1, 16'sh7fff, 6'd63, 2'd3);
    lookup(64'h0);
    send_item(ACT_STORE, '1, 64'h0, -16'sh8000, 6'd0, 2'd1);
    lookup('1);
    // occupied slot with another key misses
    send_item(ACT_STORE, ka, {$urandom, $urandom}, -16'sd1, 6'd21, 2'd2);
    lookup(kb);
    lookup(ka);
    // overwrite by the other key of the pair
    send_item(ACT_STORE, kb, {$urandom, $urandom}, 16'sd1234, 6'd42, 2'd1);
    lookup(ka);
    lookup(kb);
    // store with empty kind hides the slot
    send_item(ACT_STORE, kb, {$urandom, $urandom}, 16'sd5, 6'd5, KIND_EMPTY);
    lookup(kb);
    send_item(ACT_STORE, 64'h0, '1, 16'sd7, 6'd7, KIND_EMPTY);
    lookup(64'h0);
    send_item(ACT_STORE, 64'h0, 64'h5555_aaaa_5555_aaaa, -16'sd1, 6'd33, 2'd2);
    lookup(64'h0);
    send_item(ACT_STORE, ka, 64'haaaa_5555_aaaa_5555, 16'sd0, 6'd1, 2'd3);
    lookup(ka);

    // random part around the key pool
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300 || n == 900) begin
        // hold the sender until every lookup has answered
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      steady = (n >= 500 && n < 800);

      r = $urandom_range(99);
      if (r < 75) begin
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (r < 93) begin
        k = {$urandom, $urandom};
      end else if (r < 98) begin
        case ($urandom_range(3))
          0: k = 64'h0;
          1: k = '1;
          2: k = 64'd1 << $urandom_range(63);
          default: k = ~(64'd1 << $urandom_range(63));
        endcase
      end else begin
        k = {$urandom, $urandom};
        key_pool[$urandom_range(POOL_SIZE - 1)] = k;
      end

      act = ($urandom_range(99) < 45) ? ACT_STORE : ACT_LOOKUP;
      kd  = ($urandom_range(99) < 15) ? KIND_EMPTY : 2'($urandom_range(3, 1));
      send_item(act, k, {$urandom, $urandom}, 16'($urandom_range(16'hffff)),
                6'($urandom_range(63)), kd);
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // drain outstanding lookups, then let the last store settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("direct_mapped_hash_table_top: match");
    end else begin
      $display("direct_mapped_hash_table_top: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dmht_pkg.sv
hw/rtl/direct_mapped_hash_table_top.sv
bench/dmht_checker.sv
bench/direct_mapped_hash_table_top_tb.sv
